// ===== src/icapf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icapf_pkg
// Shared types and constants for the ICAP message length framer.
// ----------------------------------------------------------------------------
package icapf_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int WIN_DEPTH       = 14;
  localparam int WIN_BITS        = WIN_DEPTH * 8;
  localparam int OUT_LEN_W       = 24;

  // bit positions in the offsets-seen mask
  localparam int SEEN_REQ  = 0;
  localparam int SEEN_RES  = 1;
  localparam int SEEN_OPT  = 2;
  localparam int SEEN_NULL = 3;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [47:0]  PAT_REQMOD  = "REQMOD";
  localparam logic [55:0]  PAT_RESPMOD = "RESPMOD";
  localparam logic [55:0]  PAT_OPTIONS = "OPTIONS";
  localparam logic [31:0]  PAT_ICAP    = "ICAP";
  localparam logic [111:0] PAT_ENCAP   = "Encapsulated: ";
  localparam logic [71:0]  PAT_REQ     = "req-body=";
  localparam logic [71:0]  PAT_RES     = "res-body=";
  localparam logic [71:0]  PAT_OPT     = "opt-body=";
  localparam logic [79:0]  PAT_NULL    = "null-body=";
  localparam logic [15:0]  PAT_CRLF    = 16'h0D0A;
  localparam logic [31:0]  PAT_BLANK   = 32'h0D0A0D0A;
  localparam logic [39:0]  PAT_TERM0   = {"0", 32'h0D0A0D0A};
  localparam logic [87:0]  PAT_IEOF    = {"0; ieof", 32'h0D0A0D0A};

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_ENCAP  = 3'd1,
    PH_OFFS   = 3'd2,
    PH_HDREND = 3'd3,
    PH_BODY   = 3'd4,
    PH_IDLE   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_REQ  = 2'd1,
    TGT_RES  = 2'd2,
    TGT_NULL = 2'd3
  } digit_tgt_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] message_length;
    logic                 found;
  } out_item_t;

  typedef struct packed {
    logic keyword;
    logic encap;
    logic req;
    logic res;
    logic opt;
    logic nul;
    logic crlf;
    logic blank;
    logic term;
  } match_t;

endpackage : icapf_pkg
`default_nettype wire

// ===== src/icapf_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icapf_match
// Compares the tail of the byte window against the protocol keywords.
// ----------------------------------------------------------------------------
module icapf_match (
  input  wire logic [icapf_pkg::WIN_BITS-1:0] win_flat,  // newest byte in [7:0]
  output icapf_pkg::match_t                   match_o
);

  always_comb begin
    match_o.keyword = (win_flat[47:0] == icapf_pkg::PAT_REQMOD)  ||
                      (win_flat[55:0] == icapf_pkg::PAT_RESPMOD) ||
                      (win_flat[55:0] == icapf_pkg::PAT_OPTIONS) ||
                      (win_flat[31:0] == icapf_pkg::PAT_ICAP);
    match_o.encap   = (win_flat[111:0] == icapf_pkg::PAT_ENCAP);
    match_o.req     = (win_flat[71:0] == icapf_pkg::PAT_REQ);
    match_o.res     = (win_flat[71:0] == icapf_pkg::PAT_RES);
    match_o.opt     = (win_flat[71:0] == icapf_pkg::PAT_OPT);
    match_o.nul     = (win_flat[79:0] == icapf_pkg::PAT_NULL);
    match_o.crlf    = (win_flat[15:0] == icapf_pkg::PAT_CRLF);
    match_o.blank   = (win_flat[31:0] == icapf_pkg::PAT_BLANK);
    match_o.term    = (win_flat[39:0] == icapf_pkg::PAT_TERM0) ||
                      (win_flat[87:0] == icapf_pkg::PAT_IEOF);
  end

endmodule : icapf_match
`default_nettype wire

// ===== src/icapf_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icapf_core
// Framer state: phase, byte window, counters and parsed offsets. Applies one
// item per enabled cycle and flags the result it causes.
// ----------------------------------------------------------------------------
module icapf_core #(
  parameter int LENGTH_BITS = icapf_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  icapf_pkg::in_item_t       item_i,
  output logic                      res_valid_o,
  output icapf_pkg::out_item_t      res_item_o
);

  localparam int                     DEPTH   = icapf_pkg::WIN_DEPTH;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  icapf_pkg::phase_t     phase_r, phase_nxt;
  icapf_pkg::digit_tgt_t tgt_r, tgt_nxt;
  logic [7:0]             win_r    [DEPTH];
  logic [7:0]             win_nxt  [DEPTH];
  logic [7:0]             win_push [DEPTH];
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic [LENGTH_BITS-1:0] req_r, req_nxt;
  logic [LENGTH_BITS-1:0] res_r, res_nxt;
  logic [LENGTH_BITS-1:0] nul_r, nul_nxt;
  logic [LENGTH_BITS-1:0] skip_r, skip_nxt;
  logic [3:0]             seen_r, seen_nxt;
  logic                   done_r, done_nxt;

  logic [icapf_pkg::WIN_BITS-1:0] win_flat;
  icapf_pkg::match_t              match;

  logic [7:0]             b;
  logic                   eos;
  logic                   is_digit;
  logic                   digit_run;
  logic [LENGTH_BITS-1:0] acc_cur;
  logic [LENGTH_BITS+3:0] acc_wide;
  logic [LENGTH_BITS-1:0] acc_sat;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [LENGTH_BITS:0]   hdr_sum;
  logic [LENGTH_BITS-1:0] hdr_len;
  logic [LENGTH_BITS-1:0] body_max;
  logic [LENGTH_BITS-1:0] skip_init;
  logic                   hit;
  logic [LENGTH_BITS-1:0] len;
  logic [31:0]            len_ext;

  always_comb begin
    b   = item_i.data_byte;
    eos = item_i.end_of_stream;
    for (int i = 0; i < DEPTH - 1; i++) begin
      win_push[i] = win_r[i+1];
    end
    win_push[DEPTH-1] = b;
    for (int i = 0; i < DEPTH; i++) begin
      win_flat[(DEPTH-1-i)*8 +: 8] = win_push[i];
    end
  end

  icapf_match u_match (
    .win_flat (win_flat),
    .match_o  (match)
  );

  // shared arithmetic
  always_comb begin
    is_digit  = (b >= icapf_pkg::CHAR_ZERO) && (b <= icapf_pkg::CHAR_NINE);
    digit_run = (tgt_r != icapf_pkg::TGT_NONE) && is_digit;
    unique case (tgt_r)
      icapf_pkg::TGT_REQ: acc_cur = req_r;
      icapf_pkg::TGT_RES: acc_cur = res_r;
      default:            acc_cur = nul_r;
    endcase
    acc_wide = ({4'b0, acc_cur} << 3) + ({4'b0, acc_cur} << 1) +
               {{LENGTH_BITS{1'b0}}, b[3:0]};
    acc_sat  = (|acc_wide[LENGTH_BITS+3:LENGTH_BITS]) ? LEN_MAX
                                                      : acc_wide[LENGTH_BITS-1:0];
    cnt_inc  = (count_r == LEN_MAX) ? count_r : count_r + 1'b1;
    hdr_sum  = {1'b0, cnt_inc} + {1'b0, nul_r};
    hdr_len  = hdr_sum[LENGTH_BITS] ? LEN_MAX : hdr_sum[LENGTH_BITS-1:0];
    body_max = '0;
    if (seen_r[icapf_pkg::SEEN_REQ] && (req_r > body_max)) body_max = req_r;
    if (seen_r[icapf_pkg::SEEN_RES] && (res_r > body_max)) body_max = res_r;
    skip_init = (body_max == LEN_MAX) ? LEN_MAX : body_max + 1'b1;
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (!done_r) begin
      unique case (phase_r)
        icapf_pkg::PH_HUNT:   if (match.keyword) phase_nxt = icapf_pkg::PH_ENCAP;
        icapf_pkg::PH_ENCAP:  if (match.encap) phase_nxt = icapf_pkg::PH_OFFS;
        icapf_pkg::PH_OFFS: begin
          if (!digit_run && !match.req && !match.res && !match.opt && !match.nul &&
              match.crlf) begin
            phase_nxt = icapf_pkg::PH_HDREND;
          end
        end
        icapf_pkg::PH_HDREND: begin
          if (match.blank && !seen_r[icapf_pkg::SEEN_NULL]) begin
            phase_nxt = (|seen_r[2:0]) ? icapf_pkg::PH_BODY : icapf_pkg::PH_IDLE;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
    if (eos) phase_nxt = icapf_pkg::PH_HUNT;
  end

  // datapath and result
  always_comb begin
    win_nxt   = win_r;
    count_nxt = count_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    nul_nxt   = nul_r;
    skip_nxt  = skip_r;
    seen_nxt  = seen_r;
    tgt_nxt   = tgt_r;
    hit       = 1'b0;
    len       = '0;
    if (!done_r) begin
      count_nxt = cnt_inc;
      unique case (phase_r)
        icapf_pkg::PH_HUNT, icapf_pkg::PH_ENCAP: win_nxt = win_push;
        icapf_pkg::PH_OFFS: begin
          win_nxt = win_push;
          if (digit_run) begin
            unique case (tgt_r)
              icapf_pkg::TGT_REQ: req_nxt = acc_sat;
              icapf_pkg::TGT_RES: res_nxt = acc_sat;
              default:            nul_nxt = acc_sat;
            endcase
          end else begin
            tgt_nxt = icapf_pkg::TGT_NONE;
            priority if (match.req) begin
              req_nxt = '0;
              seen_nxt[icapf_pkg::SEEN_REQ] = 1'b1;
              tgt_nxt = icapf_pkg::TGT_REQ;
            end else if (match.res) begin
              res_nxt = '0;
              seen_nxt[icapf_pkg::SEEN_RES] = 1'b1;
              tgt_nxt = icapf_pkg::TGT_RES;
            end else if (match.opt) begin
              seen_nxt[icapf_pkg::SEEN_OPT] = 1'b1;
            end else if (match.nul) begin
              nul_nxt = '0;
              seen_nxt[icapf_pkg::SEEN_NULL] = 1'b1;
              tgt_nxt = icapf_pkg::TGT_NULL;
            end else begin
              tgt_nxt = icapf_pkg::TGT_NONE;
            end
          end
        end
        icapf_pkg::PH_HDREND: begin
          win_nxt = win_push;
          if (match.blank) begin
            if (seen_r[icapf_pkg::SEEN_NULL]) begin
              hit = 1'b1;
              len = hdr_len;
            end else if (|seen_r[2:0]) begin
              skip_nxt = skip_init;
              for (int i = 0; i < DEPTH; i++) win_nxt[i] = '0;
            end
          end
        end
        icapf_pkg::PH_BODY: begin
          if (skip_r != '0) begin
            skip_nxt = skip_r - 1'b1;
          end else begin
            win_nxt = win_push;
            if (match.term) begin
              hit = 1'b1;
              len = cnt_inc;
            end
          end
        end
        default: win_nxt = win_r;
      endcase
    end
    done_nxt = done_r | hit;

    res_valid_o                = hit || (eos && !done_r);
    len_ext                    = 32'(len);
    res_item_o.found           = hit;
    res_item_o.message_length  = len_ext[icapf_pkg::OUT_LEN_W-1:0];

    // end of stream: back to reset for the next stream
    if (eos) begin
      for (int i = 0; i < DEPTH; i++) win_nxt[i] = '0;
      count_nxt = '0;
      req_nxt   = '0;
      res_nxt   = '0;
      nul_nxt   = '0;
      skip_nxt  = '0;
      seen_nxt  = '0;
      tgt_nxt   = icapf_pkg::TGT_NONE;
      done_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= icapf_pkg::PH_HUNT;
      tgt_r   <= icapf_pkg::TGT_NONE;
      for (int i = 0; i < DEPTH; i++) win_r[i] <= '0;
      count_r <= '0;
      req_r   <= '0;
      res_r   <= '0;
      nul_r   <= '0;
      skip_r  <= '0;
      seen_r  <= '0;
      done_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tgt_r   <= tgt_nxt;
      win_r   <= win_nxt;
      count_r <= count_nxt;
      req_r   <= req_nxt;
      res_r   <= res_nxt;
      nul_r   <= nul_nxt;
      skip_r  <= skip_nxt;
      seen_r  <= seen_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule : icapf_core
`default_nettype wire

// ===== src/icap_message_length_framer_core.sv =====
`default_nettype none
// An accepted input passes the input register and then the result register before its result is valid.
// Throughput: one byte item per cycle while out_ready is high; a waiting result
// stalls the framer, and one more item can still be taken into the input register.
// A final byte gives at most one result item (found, or not found at end of stream).
// Reset: synchronous, active low; returns the framer to keyword hunt with all counts zero.
// ----------------------------------------------------------------------------
// icap_message_length_framer_core
// Top level: input register, framer core and result register.
// ----------------------------------------------------------------------------
module icap_message_length_framer_core #(
  parameter int LENGTH_BITS = icapf_pkg::LENGTH_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  icapf_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output icapf_pkg::out_item_t out_item
);

  logic                 in_valid_r;
  icapf_pkg::in_item_t  in_item_r;
  logic                 out_valid_r;
  icapf_pkg::out_item_t out_item_r;
  logic                 step_en;
  logic                 res_valid;
  icapf_pkg::out_item_t res_item;

  assign step_en  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
  end

  icapf_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .item_i      (in_item_r),
    .res_valid_o (res_valid),
    .res_item_o  (res_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule : icap_message_length_framer_core
`default_nettype wire
